// ----- rtl/hnorm_pkg.sv -----
// Shared types and constants for the heightmap normal generator.
// No dependencies; imported by every module of the block.
package hnorm_pkg;

  localparam int CoordW     = 12;
  localparam int QueueDepth = 4;
  localparam int LenW       = 34;
  localparam int QuoW       = 29;
  localparam int MagW       = 15;
  localparam int DivSteps   = 29;
  localparam int SqrtTop    = 14;

  typedef enum logic [2:0] {
    RegWidth = 3'd0,
    RegRows  = 3'd1,
    RegScale = 3'd2,
    RegStepU = 3'd3,
    RegStepV = 3'd4
  } reg_e;

  typedef struct packed {
    logic [9:0]  image_width;
    logic [9:0]  image_rows;
    logic [15:0] height_scale;
    logic [19:0] tex_step_u;
    logic [19:0] tex_step_v;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [7:0]        centre;
    logic [7:0]        left;
    logic [7:0]        right;
    logic [7:0]        prev;
    logic [7:0]        next;
    logic              last;
  } vert_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/hnorm_front.sv -----
// Front end: accepts pixel and drain beats, keeps the line store and window,
// and queues vertex descriptors. Depends on hnorm_pkg.
module hnorm_front import hnorm_pkg::*; #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_ROWS  = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] height_pixel_i,
  output logic       push_valid_o,
  output vert_t      push_data_o,
  input  logic       push_ready_i
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int DimW = CW + 1;
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int AW   = $clog2(2 * MAX_WIDTH);

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_P_RA = 8'b0000_0010,
    F_P_RB = 8'b0000_0100,
    F_P_WR = 8'b0000_1000,
    F_P_E1 = 8'b0001_0000,
    F_P_E2 = 8'b0010_0000,
    F_D_RD = 8'b0100_0000,
    F_D_E  = 8'b1000_0000
  } fstate_e;

  fstate_e state_q, state_d;

  logic [7:0]    mem [2*MAX_WIDTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;

  logic [CW-1:0] col_q, col_d, drain_q, drain_d;
  logic [RW-1:0] row_q, row_d;
  logic [7:0]    win_q [4];
  logic          win_upd;

  logic [7:0]    pix_q, a_q, b_q;
  logic [CW-1:0] c_q, d_q;
  logic [RW-1:0] z_q;
  logic [7:0]    rd_q [4];
  logic [2:0]    ridx_q;

  logic [DimW-1:0] w;
  logic [RW-1:0]   r;
  logic [CW-1:0]   wm1, c_in, d_in, d_left, d_right;
  logic [RW-1:0]   lr;
  logic            accept, emit1, emit2, c_last, d_last;

  function automatic logic [AW-1:0] addr(logic bank, logic [CW-1:0] idx);
    return bank ? (AW'(MAX_WIDTH) + AW'(idx)) : AW'(idx);
  endfunction

  always_comb begin
    if (cfg_i.image_width == 10'd0) begin
      w = DimW'(1);
    end else if (int'(cfg_i.image_width) > MAX_WIDTH) begin
      w = DimW'(MAX_WIDTH);
    end else begin
      w = DimW'(cfg_i.image_width);
    end
    if (cfg_i.image_rows == 10'd0) begin
      r = RW'(1);
    end else if (int'(cfg_i.image_rows) > MAX_ROWS) begin
      r = RW'(MAX_ROWS);
    end else begin
      r = RW'(cfg_i.image_rows);
    end
  end

  assign wm1     = CW'(w - DimW'(1));
  assign c_in    = (DimW'(col_q) >= w) ? wm1 : col_q;
  assign d_in    = (DimW'(drain_q) >= w) ? wm1 : drain_q;
  assign d_left  = (d_q != '0) ? d_q - CW'(1) : '0;
  assign d_right = ((DimW'(d_q) + DimW'(1)) < w) ? d_q + CW'(1) : wm1;
  assign lr      = r - RW'(1);
  assign c_last  = (c_q == wm1);
  assign d_last  = (d_q == wm1);
  assign emit1   = (z_q != '0) && (c_q != '0);
  assign emit2   = (z_q != '0) && c_last;

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    raddr = '0;
    unique case (state_q)
      F_P_RA: raddr = addr(~z_q[0], c_q);
      F_P_RB: raddr = addr(z_q[0], c_q);
      F_D_RD: begin
        case (ridx_q[1:0])
          2'd0:    raddr = addr(lr[0], d_q);
          2'd1:    raddr = addr(lr[0], d_left);
          2'd2:    raddr = addr(lr[0], d_right);
          default: raddr = (r > RW'(1)) ? addr(~lr[0], d_q) : addr(lr[0], d_q);
        endcase
      end
      default: raddr = '0;
    endcase
  end

  assign we    = (state_q == F_P_WR);
  assign waddr = addr(z_q[0], c_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= pix_q;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    drain_d      = drain_q;
    win_upd      = 1'b0;
    push_valid_o = 1'b0;
    push_data_o  = '0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (!op_i && (row_q < r)) begin
            state_d = F_P_RA;
          end else if (op_i && (row_q >= r)) begin
            state_d = F_D_RD;
          end
        end
      end
      F_P_RA: state_d = F_P_RB;
      F_P_RB: state_d = F_P_WR;
      F_P_WR: state_d = F_P_E1;
      F_P_E1: begin
        push_data_o.col    = CoordW'(c_q - CW'(1));
        push_data_o.row    = CoordW'(z_q - RW'(1));
        push_data_o.centre = win_q[1];
        push_data_o.left   = (c_q >= CW'(2)) ? win_q[2] : win_q[1];
        push_data_o.right  = a_q;
        push_data_o.prev   = (z_q >= RW'(2)) ? win_q[3] : win_q[1];
        push_data_o.next   = win_q[0];
        push_data_o.last   = 1'b0;
        push_valid_o       = emit1;
        if (!emit1 || push_ready_i) begin
          state_d = F_P_E2;
        end
      end
      F_P_E2: begin
        push_data_o.col    = CoordW'(c_q);
        push_data_o.row    = CoordW'(z_q - RW'(1));
        push_data_o.centre = a_q;
        push_data_o.left   = (c_q != '0) ? win_q[1] : a_q;
        push_data_o.right  = a_q;
        push_data_o.prev   = (z_q >= RW'(2)) ? b_q : a_q;
        push_data_o.next   = pix_q;
        push_data_o.last   = 1'b0;
        push_valid_o       = emit2;
        if (!emit2 || push_ready_i) begin
          state_d = F_IDLE;
          win_upd = 1'b1;
          if (c_last) begin
            col_d = '0;
            row_d = z_q + RW'(1);
          end else begin
            col_d = c_q + CW'(1);
          end
        end
      end
      F_D_RD: begin
        if (ridx_q == 3'd4) begin
          state_d = F_D_E;
        end
      end
      F_D_E: begin
        push_data_o.col    = CoordW'(d_q);
        push_data_o.row    = CoordW'(lr);
        push_data_o.centre = rd_q[0];
        push_data_o.left   = rd_q[1];
        push_data_o.right  = rd_q[2];
        push_data_o.prev   = rd_q[3];
        push_data_o.next   = rd_q[0];
        push_data_o.last   = d_last;
        push_valid_o       = 1'b1;
        if (push_ready_i) begin
          state_d = F_IDLE;
          if (d_last) begin
            col_d   = '0;
            row_d   = '0;
            drain_d = '0;
          end else begin
            drain_d = d_q + CW'(1);
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
      ridx_q  <= '0;
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      if (win_upd) begin
        win_q[2] <= win_q[1];
        win_q[1] <= a_q;
        win_q[3] <= b_q;
        win_q[0] <= pix_q;
      end
      if (accept) begin
        ridx_q <= '0;
      end else if (state_q == F_D_RD) begin
        ridx_q <= ridx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= height_pixel_i;
      c_q   <= c_in;
      z_q   <= row_q;
      d_q   <= d_in;
    end
    if (state_q == F_P_RB) begin
      a_q <= rdata_q;
    end
    if (state_q == F_P_WR) begin
      b_q <= rdata_q;
    end
    if ((state_q == F_D_RD) && (ridx_q != 3'd0)) begin
      rd_q[2'(ridx_q - 3'd1)] <= rdata_q;
    end
  end

endmodule

// ----- rtl/hnorm_queue.sv -----
// Short descriptor queue between the front and back ends.
// Depends on hnorm_pkg for the descriptor type and depth.
module hnorm_queue import hnorm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  input  vert_t   push_data_i,
  output logic    push_ready_o,
  output logic    pop_valid_o,
  output vert_t   pop_data_o,
  input  logic    pop_ready_i,
  output q_stat_t stat_o
);

  localparam int PW = $clog2(QueueDepth);

  vert_t        buf_q [QueueDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign stat_o.full  = (cnt_q == (PW+1)'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign push_ready_o = !stat_o.full;
  assign pop_valid_o  = !stat_o.empty;
  assign pop_data_o   = buf_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/hnorm_back.sv -----
// Back end: heights, texture coordinates and the unit normal of one vertex,
// through a shared divide and square-root unit. Depends on hnorm_pkg.
module hnorm_back import hnorm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  input  vert_t       pop_data_i,
  output logic        pop_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  col_o,
  output logic [8:0]  row_o,
  output logic [15:0] height_y_o,
  output logic [15:0] normal_x_o,
  output logic [14:0] normal_y_o,
  output logic [15:0] normal_z_o,
  output logic [15:0] tex_u_o,
  output logic [15:0] tex_v_o,
  output logic        last_o
);

  typedef enum logic [11:0] {
    B_IDLE = 12'b0000_0000_0001,
    B_HQ   = 12'b0000_0000_0010,
    B_TEXU = 12'b0000_0000_0100,
    B_TEXV = 12'b0000_0000_1000,
    B_DIFF = 12'b0000_0001_0000,
    B_SQX  = 12'b0000_0010_0000,
    B_SQZ  = 12'b0000_0100_0000,
    B_LEN  = 12'b0000_1000_0000,
    B_DIVI = 12'b0001_0000_0000,
    B_DIV  = 12'b0010_0000_0000,
    B_SQRT = 12'b0100_0000_0000,
    B_OUT  = 12'b1000_0000_0000
  } bstate_e;

  bstate_e state_q;

  vert_t            v_q;
  logic [2:0]       k_q;
  logic [15:0]      hq_q [5];
  logic [15:0]      tu_q, tv_q;
  logic             negx_q, negz_q;
  logic [15:0]      adx_q, adz_q;
  logic [31:0]      sqx_q, sqz_q;
  logic [LenW-1:0]  len_q, rem_q;
  logic [QuoW-1:0]  dd_q, quo_q;
  logic [MagW-1:0]  res_q;
  logic [MagW-1:0]  mag_q [3];
  logic [1:0]       j_q;
  logic [4:0]       cnt_q;
  logic             out_valid_q;

  logic [7:0]      hpix;
  logic [23:0]     hprod;
  logic [15:0]     hval;
  logic [16:0]     dx, dz;
  logic [31:0]     tprod;
  logic [23:0]     tshift;
  logic [31:0]     sq_sel;
  logic [LenW:0]   trial;
  logic [MagW-1:0] cand;
  logic [2*MagW-1:0] cand_sq;
  logic            load;

  function automatic logic [15:0] div255(logic [23:0] x);
    logic [31:0] t;
    logic [15:0] q0;
    logic [23:0] rm;
    t  = ({8'd0, x} << 8) + {8'd0, x};
    q0 = t[31:16];
    rm = x - (({8'd0, q0} << 8) - {8'd0, q0});
    if (rm >= 24'd510) begin
      return q0 + 16'd2;
    end else if (rm >= 24'd255) begin
      return q0 + 16'd1;
    end
    return q0;
  endfunction

  always_comb begin
    case (k_q)
      3'd0:    hpix = v_q.centre;
      3'd1:    hpix = v_q.left;
      3'd2:    hpix = v_q.right;
      3'd3:    hpix = v_q.prev;
      default: hpix = v_q.next;
    endcase
  end

  assign hprod  = {16'd0, hpix} * {8'd0, cfg_i.height_scale};
  assign hval   = div255(hprod);
  assign dx     = {1'b0, hq_q[1]} - {1'b0, hq_q[2]};
  assign dz     = {1'b0, hq_q[3]} - {1'b0, hq_q[4]};
  assign tprod  = (state_q == B_TEXU) ? {20'd0, v_q.col} * {12'd0, cfg_i.tex_step_u}
                                      : {20'd0, v_q.row} * {12'd0, cfg_i.tex_step_v};
  assign tshift = tprod[31:8];

  always_comb begin
    case (j_q)
      2'd0:    sq_sel = sqx_q;
      2'd1:    sq_sel = 32'd262144;
      default: sq_sel = sqz_q;
    endcase
  end

  assign trial   = {rem_q, dd_q[QuoW-1]};
  assign cand    = res_q | (MagW'(1) << cnt_q[3:0]);
  assign cand_sq = cand * cand;

  assign pop_ready_o = (state_q == B_IDLE);
  assign load        = (state_q == B_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            k_q     <= '0;
            state_q <= B_HQ;
          end
        end
        B_HQ: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) begin
            state_q <= B_TEXU;
          end
        end
        B_TEXU: state_q <= B_TEXV;
        B_TEXV: state_q <= B_DIFF;
        B_DIFF: state_q <= B_SQX;
        B_SQX:  state_q <= B_SQZ;
        B_SQZ:  state_q <= B_LEN;
        B_LEN: begin
          j_q     <= '0;
          state_q <= B_DIVI;
        end
        B_DIVI: begin
          cnt_q   <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          if (cnt_q == 5'(DivSteps - 1)) begin
            cnt_q   <= 5'(SqrtTop);
            state_q <= B_SQRT;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        B_SQRT: begin
          if (cnt_q == 5'd0) begin
            if (j_q == 2'd2) begin
              state_q <= B_OUT;
            end else begin
              j_q     <= j_q + 2'd1;
              state_q <= B_DIVI;
            end
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        B_OUT: begin
          if (load) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == B_IDLE) && pop_valid_i) begin
      v_q <= pop_data_i;
    end
    if (state_q == B_HQ) begin
      hq_q[k_q] <= hval;
    end
    if (state_q == B_TEXU) begin
      tu_q <= (tshift > 24'd65535) ? 16'hFFFF : tshift[15:0];
    end
    if (state_q == B_TEXV) begin
      tv_q <= (tshift > 24'd65535) ? 16'hFFFF : tshift[15:0];
    end
    if (state_q == B_DIFF) begin
      negx_q <= dx[16];
      negz_q <= dz[16];
      adx_q  <= dx[16] ? 16'(-dx) : dx[15:0];
      adz_q  <= dz[16] ? 16'(-dz) : dz[15:0];
    end
    if (state_q == B_SQX) begin
      sqx_q <= adx_q * adx_q;
    end
    if (state_q == B_SQZ) begin
      sqz_q <= adz_q * adz_q;
    end
    if (state_q == B_LEN) begin
      len_q <= LenW'(sqx_q) + LenW'(sqz_q) + LenW'(262144);
    end
    if (state_q == B_DIVI) begin
      rem_q <= LenW'(sq_sel >> 1);
      dd_q  <= {sq_sel[0], {(QuoW-1){1'b0}}};
      quo_q <= '0;
      res_q <= '0;
    end
    if (state_q == B_DIV) begin
      dd_q <= dd_q << 1;
      if (trial >= {1'b0, len_q}) begin
        rem_q <= LenW'(trial - {1'b0, len_q});
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= trial[LenW-1:0];
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
    if (state_q == B_SQRT) begin
      if (cand_sq <= {1'b0, quo_q}) begin
        res_q <= cand;
        if (cnt_q == 5'd0) begin
          mag_q[j_q] <= cand;
        end
      end else if (cnt_q == 5'd0) begin
        mag_q[j_q] <= res_q;
      end
    end
    if (load) begin
      col_o      <= v_q.col[8:0];
      row_o      <= v_q.row[8:0];
      height_y_o <= hq_q[0];
      normal_x_o <= negx_q ? 16'(-{1'b0, mag_q[0]}) : {1'b0, mag_q[0]};
      normal_y_o <= mag_q[1];
      normal_z_o <= negz_q ? 16'(-{1'b0, mag_q[2]}) : {1'b0, mag_q[2]};
      tex_u_o    <= tu_q;
      tex_v_o    <= tv_q;
      last_o     <= v_q.last;
    end
  end

endmodule

// ----- rtl/heightmap_normal_generator.sv -----
// Heightmap normal generator: vertex stream with central-difference normals.
// The back end takes a new vertex only after the last one is loaded to the
// outputs, as all three normal components go through the shared divide and
// square-root unit (29 + 15 steps per normal component); dropped items are discarded.
// Reset: registers to defaults, counters and window cleared; line store
// is not cleared and no clearing pass runs. Depends on hnorm_pkg.
module heightmap_normal_generator import hnorm_pkg::*; #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_ROWS  = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  height_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  col_o,
  output logic [8:0]  row_o,
  output logic [15:0] height_y_o,
  output logic [15:0] normal_x_o,
  output logic [14:0] normal_y_o,
  output logic [15:0] normal_z_o,
  output logic [15:0] tex_u_o,
  output logic [15:0] tex_v_o,
  output logic        last_o
);

  cfg_t    cfg_q;
  logic    push_valid, push_ready, pop_valid, pop_ready;
  vert_t   push_data, pop_data;
  q_stat_t q_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 10'd257;
      cfg_q.image_rows   <= 10'd257;
      cfg_q.height_scale <= 16'd5120;
      cfg_q.tex_step_u   <= 20'd2550;
      cfg_q.tex_step_v   <= 20'd2550;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegWidth: cfg_q.image_width  <= cfg_data_i[9:0];
        RegRows:  cfg_q.image_rows   <= cfg_data_i[9:0];
        RegScale: cfg_q.height_scale <= cfg_data_i[15:0];
        RegStepU: cfg_q.tex_step_u   <= cfg_data_i;
        RegStepV: cfg_q.tex_step_v   <= cfg_data_i;
        default:  cfg_q              <= cfg_q;
      endcase
    end
  end

  hnorm_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .height_pixel_i(height_pixel_i),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data),
    .push_ready_i  (push_ready)
  );

  hnorm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_ready_i (pop_ready),
    .stat_o      (q_stat)
  );

  hnorm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pop_valid_i(pop_valid),
    .pop_data_i (pop_data),
    .pop_ready_o(pop_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .col_o      (col_o),
    .row_o      (row_o),
    .height_y_o (height_y_o),
    .normal_x_o (normal_x_o),
    .normal_y_o (normal_y_o),
    .normal_z_o (normal_z_o),
    .tex_u_o    (tex_u_o),
    .tex_v_o    (tex_v_o),
    .last_o     (last_o)
  );

  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_ready |=> push_valid && $stable(push_data))
    else $error("front dropped a stalled descriptor");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> !in_ready_o)
    else $error("front accepts while pushing");

endmodule
